// ----- design/htp_pkg.sv -----
package htp_pkg;

    // Default for the number of fraction digits that count after a period.
    localparam int FRACTION_DIGITS_DEFAULT = 8;

    // Depth of the token queue between front and back. It must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes that the front recognises.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;

    // Widths of the fraction conversion.
    localparam int DIV_BITS = 30;   // largest power of ten used is 10^9
    localparam int REM_BITS = 36;   // fraction value times sixty
    localparam int QUO_BITS = 6;    // quotient is always below sixty

    typedef enum logic [1:0] {
        TOK_DIGIT,
        TOK_COLON,
        TOK_PERIOD,
        TOK_END
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [3:0]  digit;
    } token_t;

    typedef enum logic [1:0] {
        PHASE_WHOLE,
        PHASE_MINUTES,
        PHASE_FRACTION
    } phase_t;

    typedef enum logic [1:0] {
        BACK_RUN,
        BACK_DIV,
        BACK_SEND
    } back_state_t;

    // Power of ten for a count of fraction digits; counts above nine clamp to nine.
    function automatic logic [DIV_BITS-1:0] pow_ten(input logic [3:0] n);
        logic [DIV_BITS-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ----- design/htp_front.sv -----
module htp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
    output logic              tok_valid,
    input  logic              tok_ready,
    output htp_pkg::token_t   tok
);

    logic             tok_valid_reg;
    logic             tok_valid_next;
    htp_pkg::token_t  tok_reg;
    htp_pkg::token_t  tok_next;
    htp_pkg::token_t  cls;
    logic             cls_useful;
    logic             accept;

    // A new character is taken whenever the token stage is empty or draining.
    assign s_axis_tready = !tok_valid_reg || tok_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign tok_valid     = tok_valid_reg;
    assign tok           = tok_reg;

    // Classify the character; anything that is not a digit, separator or
    // terminator is dropped here.
    always_comb
    begin
        cls.kind   = htp_pkg::TOK_DIGIT;
        cls.digit  = 4'd0;
        cls_useful = 1'b1;
        if (s_axis_tdata >= htp_pkg::CHAR_ZERO && s_axis_tdata <= htp_pkg::CHAR_NINE)
        begin
            cls.digit = 4'(s_axis_tdata - htp_pkg::CHAR_ZERO);
        end
        else if (s_axis_tdata == htp_pkg::CHAR_COLON)
        begin
            cls.kind = htp_pkg::TOK_COLON;
        end
        else if (s_axis_tdata == htp_pkg::CHAR_PERIOD)
        begin
            cls.kind = htp_pkg::TOK_PERIOD;
        end
        else if (s_axis_tdata == htp_pkg::CHAR_NUL)
        begin
            cls.kind = htp_pkg::TOK_END;
        end
        else
        begin
            cls_useful = 1'b0;
        end
    end

    // Token stage update.
    always_comb
    begin
        tok_valid_next = tok_valid_reg && !tok_ready;
        tok_next       = tok_reg;
        if (accept && cls_useful)
        begin
            tok_valid_next = 1'b1;
            tok_next       = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

endmodule

// ----- design/htp_queue.sv -----
module htp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  htp_pkg::token_t   push_tok,
    output logic              pop_valid,
    input  logic              pop_ready,
    output htp_pkg::token_t   pop_tok
);

    htp_pkg::token_t                mem_reg [htp_pkg::QUEUE_DEPTH];
    logic [htp_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [htp_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [htp_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [htp_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [htp_pkg::QUEUE_AW:0]     count_reg;
    logic [htp_pkg::QUEUE_AW:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = count_reg != (htp_pkg::QUEUE_AW+1)'(htp_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_tok    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ----- design/htp_back.sv -----
module htp_back #(
    parameter int FRACTION_DIGITS = htp_pkg::FRACTION_DIGITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  htp_pkg::token_t   tok,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata    // [31:0] total_minutes
);

    localparam int FRAC_LIMIT = (FRACTION_DIGITS > 9) ? 9 : FRACTION_DIGITS;

    htp_pkg::back_state_t            state_reg;
    htp_pkg::back_state_t            state_next;
    htp_pkg::phase_t                 phase_reg;
    htp_pkg::phase_t                 phase_next;
    logic [31:0]                     hour_reg;
    logic [31:0]                     hour_next;
    logic [31:0]                     tail_reg;
    logic [31:0]                     tail_next;
    logic [3:0]                      count_reg;
    logic [3:0]                      count_next;
    logic [31:0]                     base_reg;
    logic [31:0]                     base_next;
    logic [htp_pkg::REM_BITS-1:0]    rem_reg;
    logic [htp_pkg::REM_BITS-1:0]    rem_next;
    logic [htp_pkg::DIV_BITS-1:0]    div_reg;
    logic [htp_pkg::DIV_BITS-1:0]    div_next;
    logic [htp_pkg::QUO_BITS-1:0]    quo_reg;
    logic [htp_pkg::QUO_BITS-1:0]    quo_next;
    logic [2:0]                      step_reg;
    logic [2:0]                      step_next;
    logic [31:0]                     result_reg;
    logic [31:0]                     result_next;

    logic                            take;
    logic [31:0]                     hour_x10;
    logic [31:0]                     tail_x10;
    logic [31:0]                     hour_x60;
    logic [htp_pkg::REM_BITS-1:0]    tail_x60;
    logic [htp_pkg::REM_BITS-1:0]    div_shifted;

    assign take = tok_ready && tok_valid;

    // Constant multiplications as shifts, adds and subtracts.
    assign hour_x10 = {hour_reg[28:0], 3'b000} + {hour_reg[30:0], 1'b0} + {28'd0, tok.digit};
    assign tail_x10 = {tail_reg[28:0], 3'b000} + {tail_reg[30:0], 1'b0} + {28'd0, tok.digit};
    assign hour_x60 = {hour_reg[25:0], 6'd0} - {hour_reg[29:0], 2'd0};
    assign tail_x60 = {tail_reg[29:0], 6'd0} - {2'd0, tail_reg, 2'd0};

    assign div_shifted = {6'd0, div_reg} << step_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htp_pkg::BACK_RUN:
            begin
                if (tok_valid && tok.kind == htp_pkg::TOK_END)
                begin
                    state_next = (phase_reg == htp_pkg::PHASE_FRACTION) ?
                                 htp_pkg::BACK_DIV : htp_pkg::BACK_SEND;
                end
            end
            htp_pkg::BACK_DIV:
            begin
                if (step_reg == 3'd0)
                begin
                    state_next = htp_pkg::BACK_SEND;
                end
            end
            htp_pkg::BACK_SEND:
            begin
                if (m_axis_tready)
                begin
                    state_next = htp_pkg::BACK_RUN;
                end
            end
            default:
            begin
                state_next = htp_pkg::BACK_RUN;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        tok_ready     = state_reg == htp_pkg::BACK_RUN;
        m_axis_tvalid = state_reg == htp_pkg::BACK_SEND;
    end

    assign m_axis_tdata = result_reg;

    // Parse state and the fraction conversion datapath.
    always_comb
    begin
        phase_next  = phase_reg;
        hour_next   = hour_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        base_next   = base_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        result_next = result_reg;

        if (take)
        begin
            case (tok.kind)
                htp_pkg::TOK_DIGIT:
                begin
                    case (phase_reg)
                        htp_pkg::PHASE_MINUTES:
                        begin
                            tail_next = tail_x10;
                        end
                        htp_pkg::PHASE_FRACTION:
                        begin
                            if (count_reg < 4'(FRAC_LIMIT))
                            begin
                                tail_next  = tail_x10;
                                count_next = count_reg + 4'd1;
                            end
                        end
                        default:
                        begin
                            hour_next = hour_x10;
                        end
                    endcase
                end
                htp_pkg::TOK_COLON:
                begin
                    if (phase_reg != htp_pkg::PHASE_MINUTES &&
                        phase_reg != htp_pkg::PHASE_FRACTION)
                    begin
                        phase_next = htp_pkg::PHASE_MINUTES;
                    end
                end
                htp_pkg::TOK_PERIOD:
                begin
                    if (phase_reg != htp_pkg::PHASE_MINUTES &&
                        phase_reg != htp_pkg::PHASE_FRACTION)
                    begin
                        phase_next = htp_pkg::PHASE_FRACTION;
                    end
                end
                htp_pkg::TOK_END:
                begin
                    // Capture the operands, then return the parse state to reset.
                    base_next   = hour_x60;
                    result_next = hour_x60 +
                                  ((phase_reg == htp_pkg::PHASE_MINUTES) ? tail_reg : 32'd0);
                    rem_next    = tail_x60;
                    div_next    = htp_pkg::pow_ten(count_reg);
                    quo_next    = '0;
                    step_next   = 3'(htp_pkg::QUO_BITS - 1);
                    phase_next  = htp_pkg::PHASE_WHOLE;
                    hour_next   = '0;
                    tail_next   = '0;
                    count_next  = '0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // One quotient bit a cycle; the quotient is below sixty, so six steps do.
        if (state_reg == htp_pkg::BACK_DIV)
        begin
            if (rem_reg >= div_shifted)
            begin
                rem_next           = rem_reg - div_shifted;
                quo_next[step_reg] = 1'b1;
            end
            step_next = step_reg - 3'd1;
            if (step_reg == 3'd0)
            begin
                result_next = base_reg + {26'd0, quo_next};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htp_pkg::BACK_RUN;
            phase_reg <= htp_pkg::PHASE_WHOLE;
            hour_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            hour_reg  <= hour_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

endmodule

// ----- design/hour_text_parser.sv -----
// Duration text parser. Characters arrive one per beat on the s_axis channel
// (tdata = char_code); a zero byte ends the text and causes one beat on the
// m_axis channel carrying the total in minutes, modulo 2^32.
// Digits before the first ':' or '.' form hours. After ':' later digits are
// added as minutes; after '.' they are a decimal fraction of an hour, and
// floor(60 * fraction) minutes are added, using the first FRACTION_DIGITS
// fraction digits only, nine at most. Other characters are dropped.
// Throughput: one character per cycle is accepted while the token queue has
// room; the back end retires one token per cycle while it is not busy with a
// result. After a '.' the terminator is followed by a bit-serial division by
// the power of ten before the result beat is sent.
// Reset clears the parse state, the token queue and the output valid; no
// result is pending afterwards.
// When the receiver holds m_axis_tready low, the result waits in its output
// register and characters keep being accepted until the four-entry token
// queue and the front stage are full, then s_axis_tready falls.
module hour_text_parser #(
    parameter int FRACTION_DIGITS = htp_pkg::FRACTION_DIGITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // [7:0] char_code
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata     // [31:0] total_minutes
);

    logic             front_valid;
    logic             front_ready;
    htp_pkg::token_t  front_tok;
    logic             back_valid;
    logic             back_ready;
    htp_pkg::token_t  back_tok;

    // Character classification.
    htp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .tok_valid     (front_valid),
        .tok_ready     (front_ready),
        .tok           (front_tok)
    );

    // Token queue between the two halves.
    htp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_tok    (back_tok)
    );

    // Accumulation, fraction conversion and result output.
    htp_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (back_valid),
        .tok_ready     (back_ready),
        .tok           (back_tok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
